FILE: src/thc_pkg.sv
// Shared constants and result payload type for the thermostat hysteresis controller.
// No dependencies.
package thc_pkg;

   localparam int ADC_BITS_DEFAULT = 10;

   // Sample scaling: scaled = (sample - 341) * 335 + 72600, units of 1/2640 degree
   localparam int SAMPLE_OFFSET = 341;
   localparam int SCALE_MUL     = 335;
   localparam int SCALE_BASE    = 72600;
   localparam int SCALE_BIAS    = SCALE_BASE - SAMPLE_OFFSET * SCALE_MUL;

   // One tenth of a degree in scaled units
   localparam int TENTH_UNITS = 264;

   localparam int HYST_W   = 7;
   localparam int BAND_W   = 15;
   localparam int CNT_W    = 8;
   localparam int BTN_NUM  = 4;

   localparam logic [HYST_W-1:0] HYST_MAX       = HYST_W'(99);
   localparam logic [HYST_W-1:0] HYST_MIN       = HYST_W'(1);
   localparam logic [CNT_W-1:0]  DEBOUNCE_RESET = CNT_W'(100);

   // Button positions in the debounce bank
   localparam int BTN_RUN  = 0;
   localparam int BTN_UP   = 1;
   localparam int BTN_DOWN = 2;
   localparam int BTN_VIEW = 3;

   typedef struct packed {
      logic              heater_on;
      logic              running;
      logic [HYST_W-1:0] hysteresis_tenths;
      logic              show_celsius;
   } rsp_payload_type;

endpackage

FILE: src/thc_channels.sv
// Valid/ready channel interfaces: poll tick input, status result, and debounce register write.
// Depends on thc_pkg.
interface thc_req_if #(
   parameter int ADC_BITS = thc_pkg::ADC_BITS_DEFAULT
);
   logic                valid;
   logic                ready;
   logic                sample_valid;
   logic [ADC_BITS-1:0] temp_sample;
   logic [ADC_BITS-1:0] setpoint_sample;
   logic                btn_run;
   logic                btn_up;
   logic                btn_down;
   logic                btn_view;

   modport source (
      output valid, sample_valid, temp_sample, setpoint_sample,
             btn_run, btn_up, btn_down, btn_view,
      input  ready
   );
   modport sink (
      input  valid, sample_valid, temp_sample, setpoint_sample,
             btn_run, btn_up, btn_down, btn_view,
      output ready
   );
endinterface

interface thc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        heater_on;
   logic                        running;
   logic [thc_pkg::HYST_W-1:0]  hysteresis_tenths;
   logic                        show_celsius;

   modport source (
      output valid, heater_on, running, hysteresis_tenths, show_celsius,
      input  ready
   );
   modport sink (
      input  valid, heater_on, running, hysteresis_tenths, show_celsius,
      output ready
   );
endinterface

interface thc_csr_if;
   logic                       valid;
   logic                       ready;
   logic [thc_pkg::CNT_W-1:0]  debounce_count;

   modport source (
      output valid, debounce_count,
      input  ready
   );
   modport sink (
      input  valid, debounce_count,
      output ready
   );
endinterface

FILE: src/thc_debounce.sv
// Debounce counter for one active-low button; pulses act once per held press.
// Depends on thc_pkg.
module thc_debounce (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       tick,
   input  logic                       level,
   input  logic [thc_pkg::CNT_W-1:0]  reload,
   output logic                       act
);
   import thc_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             acted_ff, acted_in;
   logic [CNT_W-1:0] count_dec;

   assign count_dec = count_ff - CNT_W'(1);

   always_comb begin
      count_in = count_ff;
      acted_in = acted_ff;
      act      = 1'b0;
      if (tick) begin
         if (level) begin
            // released: reload and rearm
            count_in = reload;
            acted_in = 1'b0;
         end else if (!acted_ff) begin
            count_in = count_dec;
            if (count_dec == '0) begin
               acted_in = 1'b1;
               act      = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= DEBOUNCE_RESET;
         acted_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         acted_ff <= acted_in;
      end
   end

endmodule

FILE: src/thc_out_skid.sv
// Two-entry result buffer: output register plus skid register.
// Depends on thc_pkg.
module thc_out_skid (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  thc_pkg::rsp_payload_type in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output thc_pkg::rsp_payload_type out_data
);
   import thc_pkg::*;

   logic            out_valid_ff;
   logic            skid_valid_ff;
   rsp_payload_type out_data_ff;
   rsp_payload_type skid_data_ff;
   logic            in_fire;
   logic            out_free;

   assign in_ready  = !skid_valid_ff;
   assign in_fire   = in_valid && in_ready;
   assign out_free  = !out_valid_ff || out_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= in_fire;
         end
      end else if (in_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
         end else if (in_fire) begin
            out_data_ff <= in_data;
         end
      end else if (in_fire) begin
         skid_data_ff <= in_data;
      end
   end

endmodule

FILE: src/thermostat_hysteresis_controller.sv
// Bang-bang thermostat with hysteresis, one poll tick per input beat.
// Depends on thc_pkg, thc_channels, thc_debounce and thc_out_skid.
//
// Each req beat is one poll tick: it runs the control step on the stored
// temperature and setpoint, then stores new converter samples when
// sample_valid is set, then handles four debounced active-low buttons (run
// toggle, hysteresis up/down in tenths clamped to 1..99, display toggle).
// Every tick yields exactly one rsp beat with the heater drive and the
// updated status. Throughput is one beat per clock while req_ch.ready is high;
// each result is registered in the buffer's output or skid register.
// A two-entry result buffer keeps req_ch.ready high while one result waits,
// so the input stalls only when two results are pending. The csr channel is
// always ready; a new debounce count applies at a button's next reload.
// Stored values use units of 1/2640 degree: (sample - 341) * 335 + 72600.
module thermostat_hysteresis_controller #(
   parameter int ADC_BITS = thc_pkg::ADC_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   thc_req_if.sink   req_ch,
   thc_rsp_if.source rsp_ch,
   thc_csr_if.sink   csr_ch
);
   import thc_pkg::*;

   // Scaled value width: holds the largest positive result plus sign
   localparam int SCALED_MAX = ((1 << ADC_BITS) - 1 - SAMPLE_OFFSET) * SCALE_MUL + SCALE_BASE;
   localparam int SCALED_W   = $clog2(SCALED_MAX + 1) + 1;
   localparam int CMP_W      = SCALED_W + 1;
   localparam int SAMP_CMP_W = ADC_BITS + 2;

   localparam logic signed [SCALED_W-1:0] BIAS_S = SCALED_W'(SCALE_BIAS);
   localparam logic signed [SCALED_W-1:0] MUL_S  = SCALED_W'(SCALE_MUL);
   localparam logic signed [SCALED_W-1:0] BASE_S = SCALED_W'(SCALE_BASE);

   // ---------------- configuration ----------------
   logic [CNT_W-1:0] debounce_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
      end else if (csr_ch.valid) begin
         debounce_ff <= csr_ch.debounce_count;
      end
   end

   // ---------------- state ----------------
   logic                       run_ff, run_in;
   logic                       heater_ff, heater_in;
   logic                       view_ff, view_in;
   logic [HYST_W-1:0]          hyst_ff, hyst_in;
   logic signed [SCALED_W-1:0] temp_ff, temp_in;
   logic signed [SCALED_W-1:0] set_ff, set_in;

   logic            tick;
   logic            buf_ready;
   rsp_payload_type rsp_data;

   assign tick         = req_ch.valid && buf_ready;
   assign req_ch.ready = buf_ready;

   // ---------------- control step on stored values ----------------
   logic [BAND_W-1:0]       band;
   logic signed [CMP_W-1:0] temp_ext;
   logic signed [CMP_W-1:0] low_lim;
   logic signed [CMP_W-1:0] high_lim;

   assign band     = BAND_W'(hyst_ff) * BAND_W'(TENTH_UNITS);
   assign temp_ext = CMP_W'(temp_ff);
   assign low_lim  = CMP_W'(set_ff) - $signed(CMP_W'(band));
   assign high_lim = CMP_W'(set_ff) + $signed(CMP_W'(band));

   always_comb begin
      heater_in = heater_ff;
      if (!run_ff) begin
         heater_in = 1'b0;
      end else if (temp_ext < low_lim) begin
         heater_in = 1'b1;
      end else if (temp_ext > high_lim) begin
         heater_in = 1'b0;
      end
   end

   // ---------------- sample scaling ----------------
   logic signed [SCALED_W-1:0] temp_new;
   logic signed [SCALED_W-1:0] set_new;
   logic                       set_low;

   assign temp_new = $signed({{(SCALED_W-ADC_BITS){1'b0}}, req_ch.temp_sample}) * MUL_S + BIAS_S;
   assign set_new  = $signed({{(SCALED_W-ADC_BITS){1'b0}}, req_ch.setpoint_sample}) * MUL_S
                     + BIAS_S;
   // setpoint at or below the offset clamps to the base value
   assign set_low  = SAMP_CMP_W'(req_ch.setpoint_sample) <= SAMP_CMP_W'(SAMPLE_OFFSET);

   always_comb begin
      temp_in = temp_ff;
      set_in  = set_ff;
      if (req_ch.sample_valid) begin
         temp_in = temp_new;
         set_in  = set_low ? BASE_S : set_new;
      end
   end

   // ---------------- buttons ----------------
   logic [BTN_NUM-1:0] btn_level;
   logic [BTN_NUM-1:0] btn_act;
   logic [HYST_W-1:0]  hyst_up;

   assign btn_level[BTN_RUN]  = req_ch.btn_run;
   assign btn_level[BTN_UP]   = req_ch.btn_up;
   assign btn_level[BTN_DOWN] = req_ch.btn_down;
   assign btn_level[BTN_VIEW] = req_ch.btn_view;

   for (genvar i = 0; i < BTN_NUM; i++) begin : g_btn
      thc_debounce u_debounce (
         .clock  (clock),
         .reset  (reset),
         .tick   (tick),
         .level  (btn_level[i]),
         .reload (debounce_ff),
         .act    (btn_act[i])
      );
   end

   // up is applied before down within one tick
   always_comb begin
      hyst_up = hyst_ff;
      if (btn_act[BTN_UP]) begin
         hyst_up = (hyst_ff >= HYST_MAX) ? HYST_MAX : hyst_ff + HYST_W'(1);
      end
      hyst_in = hyst_up;
      if (btn_act[BTN_DOWN]) begin
         hyst_in = (hyst_up <= HYST_MIN) ? HYST_MIN : hyst_up - HYST_W'(1);
      end
   end

   assign run_in  = run_ff ^ btn_act[BTN_RUN];
   assign view_in = view_ff ^ btn_act[BTN_VIEW];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         heater_ff <= 1'b0;
         view_ff   <= 1'b0;
         hyst_ff   <= HYST_MIN;
         temp_ff   <= '0;
         set_ff    <= '0;
      end else if (tick) begin
         run_ff    <= run_in;
         heater_ff <= heater_in;
         view_ff   <= view_in;
         hyst_ff   <= hyst_in;
         temp_ff   <= temp_in;
         set_ff    <= set_in;
      end
   end

   // ---------------- result ----------------
   rsp_payload_type tick_result;
   logic            rsp_valid;

   assign tick_result.heater_on         = heater_in;
   assign tick_result.running           = run_in;
   assign tick_result.hysteresis_tenths = hyst_in;
   assign tick_result.show_celsius      = view_in;

   thc_out_skid u_out_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (buf_ready),
      .in_data   (tick_result),
      .out_valid (rsp_valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_data)
   );

   assign rsp_ch.valid             = rsp_valid;
   assign rsp_ch.heater_on         = rsp_data.heater_on;
   assign rsp_ch.running           = rsp_data.running;
   assign rsp_ch.hysteresis_tenths = rsp_data.hysteresis_tenths;
   assign rsp_ch.show_celsius      = rsp_data.show_celsius;

endmodule

FILE: verif/thermostat_hysteresis_controller_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the thermostat hysteresis controller: poll-tick beats in,
// status beats out, checked against an in-bench thermostat model.
// Depends on thc_pkg, thc_channels and the controller RTL.
module thermostat_hysteresis_controller_tb;
   import thc_pkg::*;

   localparam int ADC_W        = ADC_BITS_DEFAULT;
   localparam int ADC_MAX      = (1 << ADC_W) - 1;
   localparam int SCALED_W     = 20;
   localparam int NO_CLIMB     = -1;
   localparam int DRAIN_CYCLES = 4;
   localparam int TIMEOUT_NS   = 2_000_000;
   localparam int ERR_PRINT    = 100;

   typedef enum bit {ROW_TICK, ROW_CSR} row_kind_type;

   // One poll tick; btn_n is active low, indexed by BTN_RUN..BTN_VIEW
   typedef struct {
      logic               sample_valid;
      logic [ADC_W-1:0]   temp_sample;
      logic [ADC_W-1:0]   setpoint_sample;
      logic [BTN_NUM-1:0] btn_n;
   } tick_type;

   typedef struct {
      row_kind_type     kind;
      logic [CNT_W-1:0] csr_val;
      tick_type         tick;
      bit               typed;
      rsp_payload_type  want;
   } dir_row_type;

   logic clock;
   logic reset;

   thc_req_if #(.ADC_BITS(ADC_W)) req_ch ();
   thc_rsp_if                     rsp_ch ();
   thc_csr_if                     csr_ch ();

   thermostat_hysteresis_controller #(.ADC_BITS(ADC_W)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // ---------------------------------------------------------------------
   // Thermostat model state (mirrors the block's architectural state)
   // ---------------------------------------------------------------------
   logic [CNT_W-1:0]           m_debounce;
   logic                       m_run;
   logic                       m_heat;
   logic                       m_view;
   logic [HYST_W-1:0]          m_hyst;
   logic signed [SCALED_W-1:0] m_temp;
   logic signed [SCALED_W-1:0] m_set;
   logic [CNT_W-1:0]           m_cnt [BTN_NUM];
   bit                         m_acted [BTN_NUM];

   rsp_payload_type pending_status [$];
   dir_row_type     dir_tab [$];
   int              mismatch_count = 0;

   // Idle knobs, shared with the response process
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_req  = 0;

   // Button level generator state: 1 = released
   bit gen_level [BTN_NUM] = '{default: 1'b1};
   int gen_left  [BTN_NUM] = '{default: 0};

   // ---------------------------------------------------------------------
   // Clock and timeout
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("** thermostat_hysteresis_controller: FAILED **");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Model
   // ---------------------------------------------------------------------
   function automatic void reset_model();
      m_debounce = DEBOUNCE_RESET;
      m_run      = 1'b0;
      m_heat     = 1'b0;
      m_view     = 1'b0;
      m_hyst     = HYST_MIN;
      m_temp     = '0;
      m_set      = '0;
      for (int b = 0; b < BTN_NUM; b++) begin
         m_cnt[b]   = DEBOUNCE_RESET;
         m_acted[b] = 1'b0;
      end
   endfunction

   // (sample - 341) * 335 + 72600, signed: low temperatures go negative
   function automatic logic signed [SCALED_W-1:0] to_scaled(input logic [ADC_W-1:0] s);
      return SCALED_W'((int'(s) - SAMPLE_OFFSET) * SCALE_MUL + SCALE_BASE);
   endfunction

   // Advance the model by one tick and return the status it reports
   function automatic rsp_payload_type thermostat_step(input tick_type t);
      rsp_payload_type r;
      int              band;
      bit              fire;
      // Control runs on values stored by earlier ticks
      if (m_run) begin
         band = int'(m_hyst) * TENTH_UNITS;
         if (int'(m_temp) < int'(m_set) - band) m_heat = 1'b1;
         else if (int'(m_temp) > int'(m_set) + band) m_heat = 1'b0;
      end else begin
         m_heat = 1'b0;
      end
      if (t.sample_valid) begin
         m_temp = to_scaled(t.temp_sample);
         // Setpoint at or below the offset clamps to the base value
         m_set  = (t.setpoint_sample <= SAMPLE_OFFSET) ? SCALED_W'(SCALE_BASE)
                                                       : to_scaled(t.setpoint_sample);
      end
      for (int b = 0; b < BTN_NUM; b++) begin
         if (t.btn_n[b]) begin
            m_cnt[b]   = m_debounce;
            m_acted[b] = 1'b0;
            fire       = 1'b0;
         end else if (m_acted[b]) begin
            fire = 1'b0;
         end else begin
            m_cnt[b]   = m_cnt[b] - 1'b1;   // wraps, so count 0 means 256 ticks
            fire       = (m_cnt[b] == '0);
            m_acted[b] = fire;
         end
         if (fire) begin
            case (b)
               BTN_RUN:  m_run = !m_run;
               BTN_UP:   if (m_hyst < HYST_MAX) m_hyst = m_hyst + 1'b1;
               BTN_DOWN: if (m_hyst > HYST_MIN) m_hyst = m_hyst - 1'b1;
               BTN_VIEW: m_view = !m_view;
               default:  ;
            endcase
         end
      end
      r.heater_on         = m_heat;
      r.running           = m_run;
      r.hysteresis_tenths = m_hyst;
      r.show_celsius      = m_view;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= ERR_PRINT) $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic check_status(input rsp_payload_type got);
      rsp_payload_type want;
      if (pending_status.size() == 0) begin
         report_mismatch("status beat with nothing expected");
         return;
      end
      want = pending_status.pop_front();
      if (got.heater_on !== want.heater_on)
         report_mismatch($sformatf("heater_on got %b want %b", got.heater_on, want.heater_on));
      if (got.running !== want.running)
         report_mismatch($sformatf("running got %b want %b", got.running, want.running));
      if (got.hysteresis_tenths !== want.hysteresis_tenths)
         report_mismatch($sformatf("hysteresis_tenths got %0d want %0d",
                                   got.hysteresis_tenths, want.hysteresis_tenths));
      if (got.show_celsius !== want.show_celsius)
         report_mismatch($sformatf("show_celsius got %b want %b",
                                   got.show_celsius, want.show_celsius));
   endtask

   // Response side: checks each accepted beat, then picks next ready.
   // A hold request parks ready low until its hold count runs out.
   initial begin : rsp_sink
      rsp_payload_type got;
      int              hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.heater_on         = rsp_ch.heater_on;
            got.running           = rsp_ch.running;
            got.hysteresis_tenths = rsp_ch.hysteresis_tenths;
            got.show_celsius      = rsp_ch.show_celsius;
            check_status(got);
         end
         if (rsp_hold_req > 0) begin
            hold_left    = rsp_hold_req;
            rsp_hold_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   // Drive one tick beat; valid stays high into the next beat unless we idle.
   task automatic send_tick(input tick_type t, input bit typed = 1'b0,
                            input rsp_payload_type want = '0);
      rsp_payload_type pred;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.sample_valid    <= t.sample_valid;
      req_ch.temp_sample     <= t.temp_sample;
      req_ch.setpoint_sample <= t.setpoint_sample;
      req_ch.btn_run         <= t.btn_n[BTN_RUN];
      req_ch.btn_up          <= t.btn_n[BTN_UP];
      req_ch.btn_down        <= t.btn_n[BTN_DOWN];
      req_ch.btn_view        <= t.btn_n[BTN_VIEW];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pred = thermostat_step(t);
      pending_status.push_back(typed ? want : pred);
   endtask

   // Stop sending and wait for every expected status beat, plus a short tail
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_debounce(input logic [CNT_W-1:0] value);
      drain_results();
      csr_ch.valid          <= 1'b1;
      csr_ch.debounce_count <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      m_debounce = value;
      csr_ch.valid <= 1'b0;
   endtask

   // Random tick: temperature mostly near the setpoint so the heater switches;
   // buttons follow press/release runs sized to the debounce count, with some noise.
   // The climb button presses for exactly the debounce count, then releases once.
   function automatic tick_type random_tick(input int climb_btn);
      tick_type t;
      int       deb;
      int       span;
      int       v;
      deb = (m_debounce == '0 || m_debounce > 8) ? 8 : int'(m_debounce);
      t.sample_valid    = ($urandom_range(3) != 0);
      t.setpoint_sample = ADC_W'($urandom_range(ADC_MAX));
      case ($urandom_range(3))
         0:       span = 4;
         1:       span = 24;
         2:       span = 110;
         default: span = -1;
      endcase
      if (span < 0) begin
         t.temp_sample = ADC_W'($urandom_range(ADC_MAX));
      end else begin
         v = int'(t.setpoint_sample) + int'($urandom_range(2 * span)) - span;
         t.temp_sample = (v < 0) ? '0 : (v > ADC_MAX) ? ADC_W'(ADC_MAX) : ADC_W'(v);
      end
      for (int b = 0; b < BTN_NUM; b++) begin
         if (gen_left[b] == 0) begin
            gen_level[b] = !gen_level[b];
            if (b == climb_btn)
               gen_left[b] = gen_level[b] ? 1 : ((m_debounce == '0) ? 256 : int'(m_debounce));
            else
               gen_left[b] = gen_level[b] ? $urandom_range(1, 3) : $urandom_range(1, deb + 2);
         end
         gen_left[b]--;
         t.btn_n[b] = gen_level[b];
      end
      if ($urandom_range(99) < 8) t.btn_n = BTN_NUM'($urandom_range(15));
      return t;
   endfunction

   task automatic run_random(input int n_ticks, input int climb_btn);
      for (int i = 0; i < n_ticks; i++) send_tick(random_tick(climb_btn));
   endtask

   // Hold one button through a long run, others released
   task automatic hold_button(input int btn, input int n_ticks);
      tick_type t;
      for (int i = 0; i < n_ticks; i++) begin
         t       = random_tick(NO_CLIMB);
         t.btn_n = '1;
         if (i >= 2 && i < n_ticks - 4) t.btn_n[btn] = 1'b0;
         send_tick(t);
      end
   endtask

   function automatic void add_row(input row_kind_type kind, input int csr_val,
                                   input bit sv, input int temp, input int setp,
                                   input logic [BTN_NUM-1:0] btn_n, input bit typed,
                                   input bit heat, input bit run, input int hyst,
                                   input bit view);
      dir_row_type r;
      r.kind                   = kind;
      r.csr_val                = CNT_W'(csr_val);
      r.tick.sample_valid      = sv;
      r.tick.temp_sample       = ADC_W'(temp);
      r.tick.setpoint_sample   = ADC_W'(setp);
      r.tick.btn_n             = btn_n;
      r.typed                  = typed;
      r.want.heater_on         = heat;
      r.want.running           = run;
      r.want.hysteresis_tenths = HYST_W'(hyst);
      r.want.show_celsius      = view;
      dir_tab.push_back(r);
   endfunction

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset_model();
      reset                  <= 1'b1;
      req_ch.valid           <= 1'b0;
      req_ch.sample_valid    <= 1'b0;
      req_ch.temp_sample     <= '0;
      req_ch.setpoint_sample <= '0;
      req_ch.btn_run         <= 1'b1;
      req_ch.btn_up          <= 1'b1;
      req_ch.btn_down        <= 1'b1;
      req_ch.btn_view        <= 1'b1;
      csr_ch.valid           <= 1'b0;
      csr_ch.debounce_count  <= '0;

      // Directed table. btn_n is {view, down, up, run}, 0 = pressed.
      // Last five columns: typed check, then heater, running, hysteresis, view.
      //      kind      csr  sv temp  setp btn_n    chk ht rn hy vw
      add_row(ROW_TICK, 0,   0, 0,    0,   4'b1111, 1,  0, 0, 1, 0); // out of reset
      add_row(ROW_TICK, 0,   1, 0,    0,   4'b1111, 1,  0, 0, 1, 0); // min samples
      add_row(ROW_TICK, 0,   1, 1023, 1023,4'b1111, 1,  0, 0, 1, 0); // max samples
      add_row(ROW_TICK, 0,   1, 340,  341, 4'b1111, 1,  0, 0, 1, 0); // setpoint clamp edge
      add_row(ROW_TICK, 0,   1, 342,  342, 4'b1111, 1,  0, 0, 1, 0);
      add_row(ROW_CSR,  1,   0, 0,    0,   4'b1111, 0,  0, 0, 0, 0); // one-tick debounce
      add_row(ROW_TICK, 0,   1, 300,  600, 4'b1111, 1,  0, 0, 1, 0); // reload counters
      add_row(ROW_TICK, 0,   0, 0,    0,   4'b1110, 1,  0, 1, 1, 0); // run on, heater lags
      add_row(ROW_TICK, 0,   0, 0,    0,   4'b1110, 1,  1, 1, 1, 0); // held: acts once
      add_row(ROW_TICK, 0,   0, 0,    0,   4'b1101, 1,  1, 1, 2, 0); // hysteresis up
      add_row(ROW_TICK, 0,   1, 900,  600, 4'b1011, 1,  1, 1, 1, 0); // down, old samples
      add_row(ROW_TICK, 0,   0, 0,    0,   4'b1111, 1,  0, 1, 1, 0); // above band: off
      add_row(ROW_TICK, 0,   0, 0,    0,   4'b1011, 1,  0, 1, 1, 0); // lower limit
      add_row(ROW_TICK, 0,   0, 0,    0,   4'b0111, 1,  0, 1, 1, 1); // view toggle
      add_row(ROW_TICK, 0,   0, 0,    0,   4'b0111, 1,  0, 1, 1, 1);
      add_row(ROW_TICK, 0,   0, 0,    0,   4'b1110, 1,  0, 0, 1, 1); // run off
      add_row(ROW_TICK, 0,   0, 0,    0,   4'b0000, 1,  0, 0, 1, 0); // all pressed
      add_row(ROW_TICK, 0,   1, 1023, 0,   4'b1111, 1,  0, 0, 1, 0);
      add_row(ROW_TICK, 0,   0, 0,    0,   4'b1110, 1,  0, 1, 1, 0); // run on again
      add_row(ROW_TICK, 0,   1, 500,  500, 4'b1111, 0,  0, 0, 0, 0); // equal: hold
      add_row(ROW_TICK, 0,   1, 499,  500, 4'b1111, 0,  0, 0, 0, 0); // one count below
      add_row(ROW_TICK, 0,   0, 0,    0,   4'b1111, 0,  0, 0, 0, 0);
      add_row(ROW_TICK, 0,   1, 501,  500, 4'b1111, 0,  0, 0, 0, 0); // one count above
      add_row(ROW_TICK, 0,   0, 0,    0,   4'b1111, 0,  0, 0, 0, 0);
      add_row(ROW_TICK, 0,   1, 0,    1023,4'b1101, 0,  0, 0, 0, 0); // negative temp
      add_row(ROW_TICK, 0,   0, 0,    0,   4'b1111, 0,  0, 0, 0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_CSR) write_debounce(dir_tab[i].csr_val);
         else send_tick(dir_tab[i].tick, dir_tab[i].typed, dir_tab[i].want);
      end

      // No idling. Long receiver hold while ticks keep coming fills the
      // output buffer and must stall req; then a full pause until drained.
      run_random(30, NO_CLIMB);
      rsp_hold_req = 60;
      run_random(40, NO_CLIMB);
      drain_results();
      run_random(30, NO_CLIMB);

      // Sender idles: hysteresis climbs into its upper limit
      send_idle_pct = 62;
      run_random(200, BTN_UP);

      // Receiver stalls, two-tick debounce: climb back down
      write_debounce(CNT_W'(2));
      send_idle_pct = 0;
      rsp_stall_pct = 62;
      run_random(100, BTN_DOWN);

      // Both sides idle lightly, mid-range debounce
      write_debounce(CNT_W'($urandom_range(3, 8)));
      send_idle_pct = 11;
      rsp_stall_pct = 11;
      run_random(100, NO_CLIMB);

      // Zero count wraps: a press needs 256 held ticks
      write_debounce(CNT_W'(0));
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_button(BTN_RUN, 262);

      // Longest real count: short presses never act
      write_debounce(CNT_W'(255));
      send_idle_pct = 11;
      rsp_stall_pct = 11;
      run_random(60, NO_CLIMB);

      drain_results();
      if (mismatch_count == 0) begin
         $display("** thermostat_hysteresis_controller: PASSED **");
      end else begin
         $display("** thermostat_hysteresis_controller: FAILED **");
      end
      $finish;
   end

endmodule
